### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the 3x3 convolution block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IC3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IC3_ASSERT_NEXT(lbl, trig, expect_expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expect_expr)) \
    else $error(msg);
`else
`define IC3_ASSERT(lbl, prop, msg)
`define IC3_ASSERT_NEXT(lbl, trig, expect_expr, msg)
`endif
`endif

### design/ic3_pkg.sv
// ---------------------------------------------------------------------------
// ic3_pkg
// Types, constants and helpers shared by the 3x3 convolution block.
// ---------------------------------------------------------------------------
package ic3_pkg;

  localparam int NUM_CH         = 3;
  localparam int COEF_W         = 12;
  localparam int KROW_W         = 36;
  localparam int IMG_W_W        = 11;
  localparam int IMG_H_W        = 16;
  localparam int NCH_W          = 2;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 16;
  localparam int DRAIN_W        = 11;
  localparam int RES0_W         = 25;
  localparam int RES_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 36;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam logic [KROW_W-1:0]  KROW_TOP_RST = 36'h000000000;
  localparam logic [KROW_W-1:0]  KROW_MID_RST = 36'h000100000;
  localparam logic [KROW_W-1:0]  KROW_BOT_RST = 36'h000000000;
  localparam logic [IMG_W_W-1:0] IMG_W_RST    = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST    = 16'd480;
  localparam logic [NCH_W-1:0]   NCH_RST      = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KROW_TOP = 3'd0,
    CFG_KROW_MID = 3'd1,
    CFG_KROW_BOT = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_NCH      = 3'd5,
    CFG_PRESERVE = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROW0,
    OP_PUSH,
    OP_FLUSH,
    OP_REPEAT
  } op_t;

  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             eof;
  } meta_t;

  typedef struct packed {
    op_t   op;
    logic  fill;
    meta_t meta;
  } stage_ctrl_t;

  typedef struct packed {
    logic signed [RES0_W-1:0] res0;
    logic signed [RES_W-1:0]  res1;
    logic signed [RES_W-1:0]  res2;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     last;
    logic                     eof;
  } result_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [KROW_W-1:0] krow,
                                                    input int unsigned tap);
    return krow[tap*COEF_W +: COEF_W];
  endfunction

endpackage

### design/ic3_if.sv
// ---------------------------------------------------------------------------
// ic3 stream interfaces
// Valid/ready channels for pixel words in and convolution result words out.
// ---------------------------------------------------------------------------
interface ic3_in_if #(
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] sample_ch0;
  logic [PIXEL_BITS-1:0] sample_ch1;
  logic [PIXEL_BITS-1:0] sample_ch2;

  modport source (output valid, mode, sample_ch0, sample_ch1, sample_ch2, input ready);
  modport sink   (input valid, mode, sample_ch0, sample_ch1, sample_ch2, output ready);
endinterface

interface ic3_out_if;
  import ic3_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RES0_W-1:0] result_ch0;
  logic signed [RES_W-1:0]  result_ch1;
  logic signed [RES_W-1:0]  result_ch2;
  logic [COL_W-1:0]         out_col;
  logic [ROW_W-1:0]         out_row;
  logic                     last_in_run;
  logic                     end_of_frame;

  modport source (output valid, result_ch0, result_ch1, result_ch2, out_col, out_row,
                  last_in_run, end_of_frame, input ready);
  modport sink   (input valid, result_ch0, result_ch1, result_ch2, out_col, out_row,
                  last_in_run, end_of_frame, output ready);
endinterface

### design/ic3_ctrl.sv
// ---------------------------------------------------------------------------
// ic3_ctrl
// Frame position counters, word acceptance and line store addressing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ic3_ctrl #(
  parameter int MAX_WIDTH  = ic3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic                                           in_mode,
  input  logic [ic3_pkg::NUM_CH-1:0][PIXEL_BITS-1:0]     in_pix,
  input  logic [ic3_pkg::IMG_W_W-1:0]                    cfg_width,
  input  logic [ic3_pkg::IMG_H_W-1:0]                    cfg_height,
  input  logic [ic3_pkg::NCH_W-1:0]                      cfg_nch,
  input  logic                                           room,
  output logic [$clog2(MAX_WIDTH)-1:0]                   rd_addr,
  output ic3_pkg::stage_ctrl_t                           c1,
  output logic [$clog2(MAX_WIDTH)-1:0]                   c1_addr,
  output logic [ic3_pkg::NUM_CH-1:0][PIXEL_BITS-1:0]     c1_pix
);
  import ic3_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W = (WMAX_W > IMG_W_W) ? WMAX_W : IMG_W_W;

  logic [WCMP_W-1:0]  width_ext, width_c, wm1;
  logic [IMG_H_W-1:0] height_c;
  logic [NCH_W-1:0]   nch_c;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;
  logic               rep_pend_r, rep_pend_nxt;
  meta_t              rep_meta_r, rep_meta_nxt;
  stage_ctrl_t        c1_r, c1_nxt;
  logic [AW-1:0]      c1_addr_r;
  logic [NUM_CH-1:0][PIXEL_BITS-1:0] c1_pix_r, pix_m;

  logic               accept, row_done, at_end;
  logic [DRAIN_W-1:0] pos;

  assign width_ext = WCMP_W'(cfg_width);
  assign height_c  = (cfg_height == '0) ? IMG_H_W'(1) : cfg_height;
  assign nch_c     = (cfg_nch == '0) ? NCH_W'(1) : cfg_nch;

  always_comb begin
    priority if (width_ext < WCMP_W'(2)) begin
      width_c = WCMP_W'(2);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      width_c = WCMP_W'(MAX_WIDTH);
    end else begin
      width_c = width_ext;
    end
  end

  assign wm1      = width_c - WCMP_W'(1);
  assign in_ready = !rep_pend_r && room;
  assign accept   = in_valid && in_ready;
  assign row_done = row_r >= height_c;
  assign pos      = in_mode ? drain_r : DRAIN_W'(col_r);
  assign at_end   = WCMP_W'(pos) >= wm1;
  assign rd_addr  = AW'(pos);

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      pix_m[ch] = (ch < int'(nch_c)) ? in_pix[ch] : '0;
    end
  end

  always_comb begin
    col_nxt           = col_r;
    row_nxt           = row_r;
    drain_nxt         = drain_r;
    rep_pend_nxt      = rep_pend_r;
    rep_meta_nxt      = rep_meta_r;
    c1_nxt.op         = OP_NONE;
    c1_nxt.fill       = (pos == '0);
    c1_nxt.meta.emit  = 1'b0;
    c1_nxt.meta.col   = COL_W'(pos - DRAIN_W'(1));
    c1_nxt.meta.row   = row_r - ROW_W'(1);
    c1_nxt.meta.last  = !at_end;
    c1_nxt.meta.eof   = 1'b0;
    if (rep_pend_r && room) begin
      c1_nxt.op    = OP_REPEAT;
      c1_nxt.meta  = rep_meta_r;
      rep_pend_nxt = 1'b0;
    end else if (accept) begin
      if (!in_mode && !row_done) begin
        c1_nxt.op        = (row_r == '0) ? OP_ROW0 : OP_PUSH;
        c1_nxt.meta.emit = (row_r != '0) && (pos != '0);
        if (at_end && (row_r != '0)) begin
          rep_pend_nxt      = 1'b1;
          rep_meta_nxt.emit = 1'b1;
          rep_meta_nxt.col  = COL_W'(pos);
          rep_meta_nxt.row  = row_r - ROW_W'(1);
          rep_meta_nxt.last = 1'b1;
          rep_meta_nxt.eof  = 1'b0;
        end
        if (at_end) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end else if (in_mode && row_done) begin
        c1_nxt.op        = OP_FLUSH;
        c1_nxt.meta.emit = (pos != '0);
        c1_nxt.meta.row  = height_c - IMG_H_W'(1);
        if (at_end) begin
          rep_pend_nxt      = 1'b1;
          rep_meta_nxt.emit = 1'b1;
          rep_meta_nxt.col  = COL_W'(pos);
          rep_meta_nxt.row  = height_c - IMG_H_W'(1);
          rep_meta_nxt.last = 1'b1;
          rep_meta_nxt.eof  = 1'b1;
          col_nxt           = '0;
          row_nxt           = '0;
          drain_nxt         = '0;
        end else begin
          drain_nxt = drain_r + DRAIN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r            <= '0;
      row_r            <= '0;
      drain_r          <= '0;
      rep_pend_r       <= 1'b0;
      c1_r.op          <= OP_NONE;
      c1_r.meta.emit   <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      drain_r    <= drain_nxt;
      rep_pend_r <= rep_pend_nxt;
      c1_r       <= c1_nxt;
    end
    rep_meta_r <= rep_meta_nxt;
    c1_addr_r  <= rd_addr;
    c1_pix_r   <= pix_m;
  end

  assign c1      = c1_r;
  assign c1_addr = c1_addr_r;
  assign c1_pix  = c1_pix_r;

  `IC3_ASSERT_NEXT(a_repeat_single, c1_r.op == OP_REPEAT, c1_r.op != OP_REPEAT,
    "two border repeat steps in a row")
  `IC3_ASSERT_NEXT(a_repeat_blocks, rep_pend_r,
    (c1_r.op == OP_NONE) || (c1_r.op == OP_REPEAT), "word taken while a repeat waits")

endmodule

### design/ic3_window.sv
// ---------------------------------------------------------------------------
// ic3_window
// Line store memory and the 3x3 window registers of every channel.
// ---------------------------------------------------------------------------
module ic3_window #(
  parameter int MAX_WIDTH  = ic3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic [$clog2(MAX_WIDTH)-1:0]                      rd_addr,
  input  ic3_pkg::stage_ctrl_t                              c1,
  input  logic [$clog2(MAX_WIDTH)-1:0]                      c1_addr,
  input  logic [ic3_pkg::NUM_CH-1:0][PIXEL_BITS-1:0]        c1_pix,
  output logic [ic3_pkg::NUM_CH-1:0][2:0][2:0][PIXEL_BITS-1:0] win,
  output ic3_pkg::meta_t                                    wmeta
);
  import ic3_pkg::*;

  localparam int LINE_W = NUM_CH * PIXEL_BITS;

  logic [2*LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*LINE_W-1:0] rd_data_r;
  logic [2*LINE_W-1:0] mem_wdata;
  logic                mem_we;

  logic [NUM_CH-1:0][PIXEL_BITS-1:0]           top_px, mid_px, bot_px;
  logic [NUM_CH-1:0][2:0][2:0][PIXEL_BITS-1:0] win_r, win_nxt;
  meta_t                                       wmeta_r;

  assign top_px    = rd_data_r[LINE_W-1:0];
  assign mid_px    = rd_data_r[2*LINE_W-1:LINE_W];
  assign bot_px    = (c1.op == OP_FLUSH) ? mid_px : c1_pix;
  assign mem_we    = (c1.op == OP_ROW0) || (c1.op == OP_PUSH);
  assign mem_wdata = (c1.op == OP_ROW0) ? {c1_pix, c1_pix} : {c1_pix, mid_px};

  always_ff @(posedge clk) begin
    rd_data_r <= line_mem[rd_addr];
    if (mem_we) begin
      line_mem[c1_addr] <= mem_wdata;
    end
  end

  always_comb begin
    logic [PIXEL_BITS-1:0] colv;
    win_nxt = win_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        colv = (r == 0) ? top_px[ch] : ((r == 1) ? mid_px[ch] : bot_px[ch]);
        unique case (c1.op)
          OP_PUSH, OP_FLUSH: begin
            win_nxt[ch][r][0] = c1.fill ? colv : win_r[ch][r][1];
            win_nxt[ch][r][1] = c1.fill ? colv : win_r[ch][r][2];
            win_nxt[ch][r][2] = colv;
          end
          OP_REPEAT: begin
            win_nxt[ch][r][0] = win_r[ch][r][1];
            win_nxt[ch][r][1] = win_r[ch][r][2];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmeta_r.emit <= 1'b0;
    end else begin
      wmeta_r <= c1.meta;
    end
    win_r <= win_nxt;
  end

  assign win   = win_r;
  assign wmeta = wmeta_r;

endmodule

### design/ic3_mac.sv
// ---------------------------------------------------------------------------
// ic3_mac
// Kernel products, per-channel sums and channel combining of one window.
// ---------------------------------------------------------------------------
module ic3_mac #(
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic [ic3_pkg::NUM_CH-1:0][2:0][2:0][PIXEL_BITS-1:0] win,
  input  ic3_pkg::meta_t                                       wmeta,
  input  logic [2:0][ic3_pkg::KROW_W-1:0]                      krow,
  input  logic [ic3_pkg::NCH_W-1:0]                            cfg_nch,
  input  logic                                                 cfg_preserve,
  output logic                                                 p_emit,
  output logic                                                 s_emit,
  output ic3_pkg::result_t                                     res
);
  import ic3_pkg::*;

  localparam int PRODW = COEF_W + PIXEL_BITS + 1;
  localparam int SUMW  = PRODW + 4;
  localparam int TOTW  = SUMW + 2;

  logic signed [PRODW-1:0] prod_r [NUM_CH][3][3];
  logic signed [SUMW-1:0]  sum_nxt [NUM_CH];
  logic signed [SUMW-1:0]  sum_r [NUM_CH];
  logic signed [TOTW-1:0]  total;
  meta_t                   pmeta_r, smeta_r;
  logic [NCH_W-1:0]        nch_c;

  assign nch_c = (cfg_nch == '0) ? NCH_W'(1) : cfg_nch;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[ch][r][c] <= coef(krow[r], c) * $signed({1'b0, win[ch][r][c]});
        end
      end
    end
  end

  always_comb begin
    logic signed [SUMW-1:0] row_sum [3];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] = SUMW'(prod_r[ch][r][0]) + SUMW'(prod_r[ch][r][1])
                   + SUMW'(prod_r[ch][r][2]);
      end
      sum_nxt[ch] = row_sum[0] + row_sum[1] + row_sum[2];
      if (ch >= int'(nch_c)) begin
        sum_nxt[ch] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmeta_r.emit <= 1'b0;
      smeta_r.emit <= 1'b0;
    end else begin
      pmeta_r <= wmeta;
      smeta_r <= pmeta_r;
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_r[ch] <= sum_nxt[ch];
    end
  end

  assign total = TOTW'(sum_r[0]) + TOTW'(sum_r[1]) + TOTW'(sum_r[2]);

  always_comb begin
    res.res0 = cfg_preserve ? sum_r[0][RES0_W-1:0] : total[RES0_W-1:0];
    res.res1 = cfg_preserve ? sum_r[1][RES_W-1:0] : '0;
    res.res2 = cfg_preserve ? sum_r[2][RES_W-1:0] : '0;
    res.col  = smeta_r.col;
    res.row  = smeta_r.row;
    res.last = smeta_r.last;
    res.eof  = smeta_r.eof;
  end

  assign p_emit = pmeta_r.emit;
  assign s_emit = smeta_r.emit;

endmodule

### design/ic3_out_fifo.sv
// ---------------------------------------------------------------------------
// ic3_out_fifo
// Result word queue between the arithmetic pipeline and the output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ic3_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  ic3_pkg::result_t               din,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ic3_pkg::result_t               dout,
  output logic [ic3_pkg::FIFO_CNT_W-1:0] count
);
  import ic3_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  result_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `IC3_ASSERT(a_no_overflow, push |-> (count_r != FIFO_CNT_W'(FIFO_DEPTH)) || pop,
    "result word pushed into a full queue")
  `IC3_ASSERT(a_empty_ptrs, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r),
    "queue empty with unequal pointers")

endmodule

### design/image_convolution_3x3_top.sv
// ---------------------------------------------------------------------------
// image_convolution_3x3_top
// 3x3 convolution with clamp-to-edge borders over a raster pixel stream.
// ---------------------------------------------------------------------------
// Pixel words enter on in_ch in raster order; a word with mode set is a flush
// word, and one flush word per column drains the last row of the frame.
// Result words leave on out_ch, one row behind the input; the last pixel of
// each row after the first gives an extra result for the right border column.
// The configuration port writes the kernel rows, frame size, channel count
// and preserve mode; the user must write it only while no word is in flight,
// and the block does not enforce it. A result word passes the control, window,
// product and sum registers into the queue. One word is accepted per cycle
// while the queue has room; after the last word of each row but the first,
// input pauses while the border result uses the arithmetic pipeline.
// Results collect in an eight-entry queue; in_ch.ready drops while queued and
// in-flight results could fill it, so a stalled receiver holds the input.
// Reset restores the configuration defaults and clears the frame counters
// and the pipeline; the line stores are not cleared and are rewritten by the
// first row of every frame.
// ---------------------------------------------------------------------------
module image_convolution_3x3_top #(
  parameter int MAX_WIDTH  = ic3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ic3_in_if.sink                            in_ch,
  ic3_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ic3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ic3_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PEND_W = $clog2(FIFO_DEPTH + 5);

  logic [KROW_W-1:0]  ktop_r, kmid_r, kbot_r;
  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;
  logic [NCH_W-1:0]   nch_r;
  logic               preserve_r;

  logic [2:0][KROW_W-1:0]                      krow;
  logic [NUM_CH-1:0][PIXEL_BITS-1:0]           in_pix, c1_pix;
  logic [AW-1:0]                               rd_addr, c1_addr;
  stage_ctrl_t                                 c1;
  logic [NUM_CH-1:0][2:0][2:0][PIXEL_BITS-1:0] win;
  meta_t                                       wmeta;
  logic                                        p_emit, s_emit, room, in_ready;
  result_t                                     res, dout;
  logic [FIFO_CNT_W-1:0]                       fifo_cnt;
  logic [PEND_W-1:0]                           pending;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r     <= KROW_TOP_RST;
      kmid_r     <= KROW_MID_RST;
      kbot_r     <= KROW_BOT_RST;
      width_r    <= IMG_W_RST;
      height_r   <= IMG_H_RST;
      nch_r      <= NCH_RST;
      preserve_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KROW_TOP: ktop_r     <= cfg_data[KROW_W-1:0];
        CFG_KROW_MID: kmid_r     <= cfg_data[KROW_W-1:0];
        CFG_KROW_BOT: kbot_r     <= cfg_data[KROW_W-1:0];
        CFG_WIDTH:    width_r    <= cfg_data[IMG_W_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_data[IMG_H_W-1:0];
        CFG_NCH:      nch_r      <= cfg_data[NCH_W-1:0];
        CFG_PRESERVE: preserve_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign krow   = {kbot_r, kmid_r, ktop_r};
  assign in_pix = {in_ch.sample_ch2, in_ch.sample_ch1, in_ch.sample_ch0};

  assign pending = PEND_W'(fifo_cnt) + PEND_W'(c1.meta.emit) + PEND_W'(wmeta.emit)
                 + PEND_W'(p_emit) + PEND_W'(s_emit);
  assign room    = pending < PEND_W'(FIFO_DEPTH);

  ic3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_mode    (in_ch.mode),
    .in_pix     (in_pix),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_nch    (nch_r),
    .room       (room),
    .rd_addr    (rd_addr),
    .c1         (c1),
    .c1_addr    (c1_addr),
    .c1_pix     (c1_pix)
  );

  assign in_ch.ready = in_ready;

  ic3_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .c1      (c1),
    .c1_addr (c1_addr),
    .c1_pix  (c1_pix),
    .win     (win),
    .wmeta   (wmeta)
  );

  ic3_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .win          (win),
    .wmeta        (wmeta),
    .krow         (krow),
    .cfg_nch      (nch_r),
    .cfg_preserve (preserve_r),
    .p_emit       (p_emit),
    .s_emit       (s_emit),
    .res          (res)
  );

  ic3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s_emit),
    .din       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (dout),
    .count     (fifo_cnt)
  );

  assign out_ch.result_ch0   = dout.res0;
  assign out_ch.result_ch1   = dout.res1;
  assign out_ch.result_ch2   = dout.res2;
  assign out_ch.out_col      = dout.col;
  assign out_ch.out_row      = dout.row;
  assign out_ch.last_in_run  = dout.last;
  assign out_ch.end_of_frame = dout.eof;

endmodule
